### sv/dgsp_pkg.sv
package dgsp_pkg;

   localparam int unsigned POLL_INTERVAL_MS_DEF = 10;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned ADDR_W = 7;
   localparam int unsigned LIMIT_W = 16;
   localparam int unsigned MAP_W = 40;
   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [ADDR_W-1:0] SENSOR_A_ADDRESS_RST = 7'd16;
   localparam logic [ADDR_W-1:0] SENSOR_B_ADDRESS_RST = 7'd17;
   localparam logic [LIMIT_W-1:0] BUS_HANG_LIMIT_RST = 16'd100;
   localparam logic [LIMIT_W-1:0] ORDER_HOLD_RST = 16'd500;
   localparam logic [MAP_W-1:0] REGISTER_MAP_RST = 40'h05_04_08_0A_00;

   localparam logic [7:0] STATUS_GESTURE_MASK = 8'h1C;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SENSOR_A_ADDRESS = 3'd0,
      CSR_SENSOR_B_ADDRESS = 3'd1,
      CSR_BUS_HANG_LIMIT = 3'd2,
      CSR_ORDER_HOLD = 3'd3,
      CSR_REGISTER_MAP = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      MAP_STATUS = 3'd0,
      MAP_Z = 3'd1,
      MAP_X = 3'd2,
      MAP_GESTURE = 3'd3,
      MAP_SPEED = 3'd4
   } map_slot_type;

   typedef enum logic [1:0] {
      BUS_CMD_NONE = 2'd0,
      BUS_CMD_WRITE_PTR = 2'd1,
      BUS_CMD_READ_BYTE = 2'd2
   } bus_cmd_type;

   typedef enum logic [4:0] {
      PH_IDLE = 5'd0,
      PH_STATUS_PTR = 5'd1,
      PH_STATUS_REQ = 5'd2,
      PH_STATUS_REQ_WAIT = 5'd3,
      PH_STATUS_RX = 5'd4,
      PH_Z_PTR = 5'd5,
      PH_Z_REQ = 5'd6,
      PH_Z_REQ_WAIT = 5'd7,
      PH_Z_RX = 5'd8,
      PH_X_PTR = 5'd9,
      PH_X_REQ = 5'd10,
      PH_X_REQ_WAIT = 5'd11,
      PH_X_RX = 5'd12,
      PH_GESTURE = 5'd14,
      PH_GES_PTR = 5'd15,
      PH_GES_REQ = 5'd16,
      PH_GES_REQ_WAIT = 5'd17,
      PH_GES_RX = 5'd18,
      PH_SPD_PTR = 5'd19,
      PH_SPD_REQ = 5'd20,
      PH_SPD_REQ_WAIT = 5'd21,
      PH_SPD_RX = 5'd22,
      PH_DONE = 5'd24
   } phase_type;

   typedef struct packed {
      logic [ADDR_W-1:0] sensor_a_address;
      logic [ADDR_W-1:0] sensor_b_address;
      logic [LIMIT_W-1:0] bus_hang_limit_ms;
      logic [LIMIT_W-1:0] order_hold_ms;
      logic [MAP_W-1:0] register_map;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic bus_done;
      logic byte_ready;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0] bus_command;
      logic bus_reset;
      logic [ADDR_W-1:0] target_address;
      logic [7:0] register_pointer;
      logic updated_sensor;
      logic position_fresh;
      logic [7:0] x_position;
      logic [7:0] z_position;
      logic gesture_taken;
      logic [7:0] gesture_code;
      logic [7:0] swipe_speed;
      logic first_sensor;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0] rank_a;
      logic [1:0] rank_b;
      logic [TIME_W-1:0] stamp;
      logic leader;
   } order_type;

endpackage

### sv/dgsp_channels.sv
interface dgsp_req_if;
   import dgsp_pkg::*;

   logic valid;
   logic ready;
   logic [TIME_W-1:0] now_ms;
   logic bus_done;
   logic byte_ready;
   logic [7:0] rx_byte;

   modport source (output valid, now_ms, bus_done, byte_ready, rx_byte, input ready);
   modport sink (input valid, now_ms, bus_done, byte_ready, rx_byte, output ready);
endinterface

interface dgsp_rsp_if;
   import dgsp_pkg::*;

   logic valid;
   logic ready;
   logic [1:0] bus_command;
   logic bus_reset;
   logic [ADDR_W-1:0] target_address;
   logic [7:0] register_pointer;
   logic updated_sensor;
   logic position_fresh;
   logic [7:0] x_position;
   logic [7:0] z_position;
   logic gesture_taken;
   logic [7:0] gesture_code;
   logic [7:0] swipe_speed;
   logic first_sensor;

   modport source (output valid, bus_command, bus_reset, target_address, register_pointer,
                   updated_sensor, position_fresh, x_position, z_position, gesture_taken,
                   gesture_code, swipe_speed, first_sensor, input ready);
   modport sink (input valid, bus_command, bus_reset, target_address, register_pointer,
                 updated_sensor, position_fresh, x_position, z_position, gesture_taken,
                 gesture_code, swipe_speed, first_sensor, output ready);
endinterface

interface dgsp_csr_if;
   import dgsp_pkg::*;

   logic valid;
   logic ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [MAP_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

### sv/dgsp_engine.sv
module dgsp_engine #(
   parameter int unsigned POLL_INTERVAL_MS = dgsp_pkg::POLL_INTERVAL_MS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  dgsp_pkg::req_item_type item,
   input  dgsp_pkg::cfg_type      cfg,
   output dgsp_pkg::rsp_item_type result
);
   import dgsp_pkg::*;

   localparam logic [TIME_W-1:0] INTERVAL = TIME_W'(POLL_INTERVAL_MS);

   function automatic logic [7:0] map_byte(logic [MAP_W-1:0] map, map_slot_type slot);
      return map[{slot, 3'b000} +: 8];
   endfunction

   function automatic order_type order_refresh(order_type o, logic f_a, logic f_b,
                                               logic [TIME_W-1:0] now,
                                               logic [LIMIT_W-1:0] hold);
      order_type r;
      r = o;
      if (f_a && r.rank_b == 2'd0) r.rank_a = 2'd1;
      if (f_b && r.rank_a == 2'd0) r.rank_b = 2'd1;
      if (f_a && r.rank_b == 2'd1) r.rank_a = 2'd2;
      if (f_b && r.rank_a == 2'd1) r.rank_b = 2'd2;
      if (f_a || f_b) r.stamp = now;
      if (TIME_W'(now - r.stamp) > TIME_W'(hold)) begin
         r.rank_a = 2'd0;
         r.rank_b = 2'd0;
      end
      r.leader = (r.rank_b == 2'd1);
      return r;
   endfunction

   phase_type phase_ff, phase_in;
   logic active_ff, active_in;
   logic [TIME_W-1:0] npt_ff, npt_in;
   logic [TIME_W-1:0] idle_since_ff, idle_since_in;
   order_type ord_ff, ord_in;
   logic [7:0] held_ff, held_in;
   logic [7:0] status_ff [2];
   logic [7:0] status_in [2];
   logic [7:0] xf_ff [2];
   logic [7:0] xf_in [2];
   logic [7:0] zf_ff [2];
   logic [7:0] zf_in [2];
   logic [7:0] gcode_ff [2];
   logic [7:0] gcode_in [2];
   logic [7:0] gspeed_ff [2];
   logic [7:0] gspeed_in [2];

   logic s;
   bus_cmd_type cmd;
   logic [7:0] ptr;
   logic fpos, fges, rst, flip_done, flip_hang;

   assign s = active_ff;

   always_comb begin
      phase_in = phase_ff;
      npt_in = npt_ff;
      idle_since_in = idle_since_ff;
      ord_in = ord_ff;
      held_in = held_ff;
      status_in = status_ff;
      xf_in = xf_ff;
      zf_in = zf_ff;
      gcode_in = gcode_ff;
      gspeed_in = gspeed_ff;
      cmd = BUS_CMD_NONE;
      ptr = '0;
      fpos = 1'b0;
      fges = 1'b0;
      rst = 1'b0;
      flip_done = 1'b0;
      flip_hang = 1'b0;

      if (item.bus_done && phase_in[0]) begin
         phase_in = phase_type'(phase_in + 5'd1);
         idle_since_in = item.now_ms;
      end
      if (phase_in == PH_IDLE && item.now_ms > npt_in) begin
         npt_in = npt_in + INTERVAL;
         if (npt_in < item.now_ms) npt_in = item.now_ms + INTERVAL;
         cmd = BUS_CMD_WRITE_PTR;
         ptr = map_byte(cfg.register_map, MAP_STATUS);
         phase_in = PH_STATUS_PTR;
      end
      if (phase_in == PH_STATUS_REQ) begin
         cmd = BUS_CMD_READ_BYTE;
         phase_in = PH_STATUS_REQ_WAIT;
      end
      if (phase_in == PH_STATUS_RX && item.byte_ready) begin
         status_in[s] = item.rx_byte;
         if (item.rx_byte[0]) begin
            cmd = BUS_CMD_WRITE_PTR;
            ptr = map_byte(cfg.register_map, MAP_Z);
            phase_in = PH_Z_PTR;
         end else begin
            phase_in = PH_GESTURE;
         end
      end
      if (phase_in == PH_Z_REQ) begin
         cmd = BUS_CMD_READ_BYTE;
         phase_in = PH_Z_REQ_WAIT;
      end
      if (phase_in == PH_Z_RX && item.byte_ready) begin
         held_in = item.rx_byte;
         cmd = BUS_CMD_WRITE_PTR;
         ptr = map_byte(cfg.register_map, MAP_X);
         phase_in = PH_X_PTR;
      end
      if (phase_in == PH_X_REQ) begin
         cmd = BUS_CMD_READ_BYTE;
         phase_in = PH_X_REQ_WAIT;
      end
      if (phase_in == PH_X_RX && item.byte_ready) begin
         xf_in[s] = {1'b0, xf_ff[s][7:1]} + {1'b0, item.rx_byte[7:1]};
         zf_in[s] = {1'b0, zf_ff[s][7:1]} + {1'b0, held_in[7:1]};
         fpos = 1'b1;
         ord_in = order_refresh(ord_in, ~s, s, item.now_ms, cfg.order_hold_ms);
         phase_in = PH_GESTURE;
      end
      if (phase_in == PH_GESTURE) begin
         if ((status_in[s] & STATUS_GESTURE_MASK) != 8'd0) begin
            cmd = BUS_CMD_WRITE_PTR;
            ptr = map_byte(cfg.register_map, MAP_GESTURE);
            phase_in = PH_GES_PTR;
         end else begin
            phase_in = PH_DONE;
         end
      end
      if (phase_in == PH_GES_REQ) begin
         cmd = BUS_CMD_READ_BYTE;
         phase_in = PH_GES_REQ_WAIT;
      end
      if (phase_in == PH_GES_RX && item.byte_ready) begin
         held_in = item.rx_byte;
         cmd = BUS_CMD_WRITE_PTR;
         ptr = map_byte(cfg.register_map, MAP_SPEED);
         phase_in = PH_SPD_PTR;
      end
      if (phase_in == PH_SPD_REQ) begin
         cmd = BUS_CMD_READ_BYTE;
         phase_in = PH_SPD_REQ_WAIT;
      end
      if (phase_in == PH_SPD_RX && item.byte_ready) begin
         gcode_in[s] = held_in;
         gspeed_in[s] = item.rx_byte;
         fges = 1'b1;
         phase_in = PH_DONE;
      end
      if (phase_in == PH_DONE) begin
         phase_in = PH_IDLE;
         ord_in = order_refresh(ord_in, (fpos | fges) & ~s, (fpos | fges) & s,
                                item.now_ms, cfg.order_hold_ms);
         flip_done = 1'b1;
      end
      if (TIME_W'(item.now_ms - idle_since_in) > TIME_W'(cfg.bus_hang_limit_ms)) begin
         rst = 1'b1;
         idle_since_in = item.now_ms;
         npt_in = item.now_ms;
         ord_in = '0;
         fpos = 1'b0;
         fges = 1'b0;
         phase_in = PH_IDLE;
         flip_hang = 1'b1;
      end
      active_in = active_ff ^ flip_done ^ flip_hang;
   end

   always_comb begin
      result.bus_command = cmd;
      result.bus_reset = rst;
      result.target_address = (cmd == BUS_CMD_NONE) ? '0 :
                              (s ? cfg.sensor_b_address : cfg.sensor_a_address);
      result.register_pointer = (cmd == BUS_CMD_WRITE_PTR) ? ptr : 8'd0;
      result.updated_sensor = s;
      result.position_fresh = fpos;
      result.x_position = xf_in[s];
      result.z_position = zf_in[s];
      result.gesture_taken = fges;
      result.gesture_code = gcode_in[s];
      result.swipe_speed = gspeed_in[s];
      result.first_sensor = ord_in.leader;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         active_ff <= 1'b0;
         npt_ff <= '0;
         idle_since_ff <= '0;
         ord_ff <= '0;
         held_ff <= '0;
         for (int i = 0; i < 2; i++) begin
            status_ff[i] <= '0;
            xf_ff[i] <= '0;
            zf_ff[i] <= '0;
            gcode_ff[i] <= '0;
            gspeed_ff[i] <= '0;
         end
      end else if (step) begin
         phase_ff <= phase_in;
         active_ff <= active_in;
         npt_ff <= npt_in;
         idle_since_ff <= idle_since_in;
         ord_ff <= ord_in;
         held_ff <= held_in;
         status_ff <= status_in;
         xf_ff <= xf_in;
         zf_ff <= zf_in;
         gcode_ff <= gcode_in;
         gspeed_ff <= gspeed_in;
      end
   end

endmodule

### sv/dual_gesture_sensor_poller.sv
// Polls two gesture sensors in turn, one poll tick per request transaction and exactly one
// response transaction per tick, carrying the bus command to issue, the bus reset flag and
// the filtered positions and gesture bytes of the sensor that was active at the start of the
// tick. A tick passes through an input register and then a result register before its
// response is offered, and it waits in the input register while an earlier response is
// stalled; a new tick is taken every cycle as long as the response side keeps up. The whole
// step for a tick is one pass of logic between those two registers. Configuration writes are
// always accepted, are registered, and take effect from the next tick that is stepped.
module dual_gesture_sensor_poller #(
   parameter int unsigned POLL_INTERVAL_MS = dgsp_pkg::POLL_INTERVAL_MS_DEF
) (
   input logic     clock,
   input logic     reset,
   dgsp_req_if.sink   req_ch,
   dgsp_rsp_if.source rsp_ch,
   dgsp_csr_if.sink   csr_ch
);
   import dgsp_pkg::*;

   cfg_type cfg_ff;
   req_item_type in_ff;
   logic in_valid_ff;
   rsp_item_type rsp_ff;
   logic rsp_valid_ff;
   rsp_item_type step_result;
   logic advance;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   dgsp_engine #(
      .POLL_INTERVAL_MS(POLL_INTERVAL_MS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_ff.now_ms <= req_ch.now_ms;
         in_ff.bus_done <= req_ch.bus_done;
         in_ff.byte_ready <= req_ch.byte_ready;
         in_ff.rx_byte <= req_ch.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_a_address <= SENSOR_A_ADDRESS_RST;
         cfg_ff.sensor_b_address <= SENSOR_B_ADDRESS_RST;
         cfg_ff.bus_hang_limit_ms <= BUS_HANG_LIMIT_RST;
         cfg_ff.order_hold_ms <= ORDER_HOLD_RST;
         cfg_ff.register_map <= REGISTER_MAP_RST;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CSR_SENSOR_A_ADDRESS: cfg_ff.sensor_a_address <= csr_ch.wdata[ADDR_W-1:0];
            CSR_SENSOR_B_ADDRESS: cfg_ff.sensor_b_address <= csr_ch.wdata[ADDR_W-1:0];
            CSR_BUS_HANG_LIMIT:   cfg_ff.bus_hang_limit_ms <= csr_ch.wdata[LIMIT_W-1:0];
            CSR_ORDER_HOLD:       cfg_ff.order_hold_ms <= csr_ch.wdata[LIMIT_W-1:0];
            CSR_REGISTER_MAP:     cfg_ff.register_map <= csr_ch.wdata;
            default: ;
         endcase
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.bus_command = rsp_ff.bus_command;
   assign rsp_ch.bus_reset = rsp_ff.bus_reset;
   assign rsp_ch.target_address = rsp_ff.target_address;
   assign rsp_ch.register_pointer = rsp_ff.register_pointer;
   assign rsp_ch.updated_sensor = rsp_ff.updated_sensor;
   assign rsp_ch.position_fresh = rsp_ff.position_fresh;
   assign rsp_ch.x_position = rsp_ff.x_position;
   assign rsp_ch.z_position = rsp_ff.z_position;
   assign rsp_ch.gesture_taken = rsp_ff.gesture_taken;
   assign rsp_ch.gesture_code = rsp_ff.gesture_code;
   assign rsp_ch.swipe_speed = rsp_ff.swipe_speed;
   assign rsp_ch.first_sensor = rsp_ff.first_sensor;

endmodule

### sv/dgsp_checker.sv
module dgsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] bus_command,
   input logic       bus_reset,
   input logic [6:0] target_address,
   input logic [7:0] register_pointer,
   input logic       position_fresh,
   input logic       gesture_taken,
   input logic       first_sensor
);
   import dgsp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(bus_command) && $stable(bus_reset)
         && $stable(target_address) && $stable(register_pointer))
      else $error("Stalled response transaction changed.");

   a_cmd_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> bus_command == BUS_CMD_NONE || bus_command == BUS_CMD_WRITE_PTR
         || bus_command == BUS_CMD_READ_BYTE)
      else $error("Undefined bus command.");

   a_idle_address: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && bus_command == BUS_CMD_NONE |-> target_address == 7'd0)
      else $error("Target address set without a bus command.");

   a_pointer_write_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && bus_command != BUS_CMD_WRITE_PTR |-> register_pointer == 8'd0)
      else $error("Register pointer set without a pointer write.");

   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && bus_reset |-> !position_fresh && !gesture_taken && !first_sensor)
      else $error("Bus reset left fresh data or arrival order in place.");

endmodule

bind dual_gesture_sensor_poller dgsp_checker u_dgsp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .bus_command      (rsp_ch.bus_command),
   .bus_reset        (rsp_ch.bus_reset),
   .target_address   (rsp_ch.target_address),
   .register_pointer (rsp_ch.register_pointer),
   .position_fresh   (rsp_ch.position_fresh),
   .gesture_taken    (rsp_ch.gesture_taken),
   .first_sensor     (rsp_ch.first_sensor)
);
